// ===== rtl/core/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the coordinate hash table
// Slot layout, request and result payloads, codes, and the home slot hash.
// ----------------------------------------------------------------------------
package cht_pkg;

   // Table geometry
   localparam int TABLE_SLOTS = 8192;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
   localparam int COUNT_W     = SLOT_BITS + 1;
   localparam logic [SLOT_BITS-1:0] SLOT_MAX = SLOT_BITS'(TABLE_SLOTS - 1);

   // Field widths
   localparam int COORD_W       = 24;
   localparam int HANDLE_W      = 12;
   localparam int ENTRY_COUNT_W = 14;
   localparam int LIMIT_W       = 14;

   // Fill limit after reset: three quarters of the slots
   localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = LIMIT_W'(TABLE_SLOTS * 3 / 4);

   // Multiplicative hash constants
   localparam logic [31:0] HASH_MUL_X = 32'h9E3779B1;
   localparam logic [31:0] HASH_MUL_Z = 32'h85EBCA77;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_FILL_LIMIT = '0;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_ABSENT = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_SHIFT_RD,
      S_SHIFT_DAT,
      S_SHIFT_DEC
   } state_type;

   typedef struct packed {
      op_type                     opcode;
      logic signed [COORD_W-1:0]  tile_x;
      logic signed [COORD_W-1:0]  tile_z;
      logic [HANDLE_W-1:0]        tile_handle;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [HANDLE_W-1:0]        found_handle;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
   } rsp_type;

   typedef struct packed {
      logic                       valid;
      logic [COORD_W-1:0]         x;
      logic [COORD_W-1:0]         z;
      logic [HANDLE_W-1:0]        handle;
   } slot_type;

   typedef struct packed {
      logic                       we;
      logic [SLOT_BITS-1:0]       waddr;
      slot_type                   wdata;
      logic                       re;
      logic [SLOT_BITS-1:0]       raddr;
   } mem_req_type;

   // Home slot of a key. The low bits of a product depend only on the low
   // bits of its operands, so the sign extension to 32 bits drops out.
   function automatic logic [SLOT_BITS-1:0] slot_hash(
      input logic [COORD_W-1:0] x,
      input logic [COORD_W-1:0] z
   );
      logic [SLOT_BITS-1:0] px;
      logic [SLOT_BITS-1:0] pz;
      px = x[SLOT_BITS-1:0] * HASH_MUL_X[SLOT_BITS-1:0];
      pz = z[SLOT_BITS-1:0] * HASH_MUL_Z[SLOT_BITS-1:0];
      return px ^ pz;
   endfunction

   // Pack one result item
   function automatic rsp_type make_rsp(
      input status_type          status,
      input logic [HANDLE_W-1:0] handle,
      input logic [COUNT_W-1:0]  count
   );
      rsp_type r;
      r.status       = status;
      r.found_handle = handle;
      r.entry_count  = ENTRY_COUNT_W'(count);
      return r;
   endfunction

endpackage

// ===== rtl/core/coordinate_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// coordinate_hash_table_core: open-addressing map from tile coordinates
// Maps a signed (tile_x, tile_z) key to a 12-bit tile handle, with linear
// probing and backward-shift removal.
//
// Request channel: drive req_data and raise start; the item is taken at the
// clock edge where start is high and busy is low. busy stays high until the
// item is finished.
// Result channel: exactly one result per item, shown on rsp_data for one
// cycle with rsp_valid high. The receiver cannot stall it; the strobe comes
// in the same cycle that busy falls, so the next item may be taken at once.
// Steps: find, insert and remove hash the key, then probe the chain one
// slot read per cycle from the single read port. A remove then walks the
// rest of the chain (read, rehash, move for each occupied slot) and stops
// at the empty slot that ends the walk. An insert refused for fill is
// answered from the hash step. Clear and reset both sweep the slot memory,
// one slot a cycle, with busy high. After reset no result is given; a clear
// answers at the end of its sweep. Registers are to be written only while
// busy is low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module coordinate_hash_table_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cht_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output cht_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cht_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cht_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cht_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import cht_pkg::*;

   logic [LIMIT_W-1:0] fill_limit;
   mem_req_type        mem_req;
   slot_type           rd_data;

   cht_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .fill_limit (fill_limit)
   );

   cht_slot_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cht_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fill_limit (fill_limit),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

endmodule

// ===== rtl/core/cht_slot_ram.sv =====
// ----------------------------------------------------------------------------
// cht_slot_ram: slot memory of the coordinate hash table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cht_slot_ram (
   input  logic                 clock,
   input  cht_pkg::mem_req_type mem_req,
   output cht_pkg::slot_type    rd_data
);
   import cht_pkg::*;

   slot_type mem [TABLE_SLOTS];
   slot_type rd_data_ff;

   // Write one slot
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Read one slot, hold the data until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cht_csr.sv =====
// ----------------------------------------------------------------------------
// cht_csr: register port of the coordinate hash table
// Holds the fill limit; APB-style writes and reads, always ready.
// ----------------------------------------------------------------------------
module cht_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cht_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cht_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cht_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [cht_pkg::LIMIT_W-1:0]       fill_limit
);
   import cht_pkg::*;

   logic [CSR_ADDR_W-3:0] reg_index;
   logic                  wr_en;
   logic [LIMIT_W-1:0]    fill_limit_ff;
   logic [LIMIT_W-1:0]    fill_limit_in;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite && pready;

   // Decode the write
   always_comb begin
      fill_limit_in = fill_limit_ff;
      if (wr_en && (reg_index == REG_FILL_LIMIT)) begin
         fill_limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_limit_ff <= FILL_LIMIT_RESET;
      end else begin
         fill_limit_ff <= fill_limit_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_index)
         REG_FILL_LIMIT: prdata = CSR_DATA_W'(fill_limit_ff);
         default:        prdata = '0;
      endcase
   end

   assign fill_limit = fill_limit_ff;

endmodule

// ===== rtl/core/cht_seq.sv =====
// ----------------------------------------------------------------------------
// cht_seq: request sequencer of the coordinate hash table
// Hashes the key, probes slots one a cycle, inserts, removes with backward
// shift, and sweeps the memory on reset and clear.
// ----------------------------------------------------------------------------
module cht_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  cht_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output cht_pkg::rsp_type             rsp_data,
   input  logic [cht_pkg::LIMIT_W-1:0]  fill_limit,
   output cht_pkg::mem_req_type         mem_req,
   input  cht_pkg::slot_type            rd_data
);
   import cht_pkg::*;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [SLOT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0]  hole_ff, hole_in;
   logic [SLOT_BITS-1:0]  k_ff, k_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [HANDLE_W-1:0]   found_ff, found_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [31:0]           limit_eff;
   logic                  table_full;
   logic                  key_hit;
   logic                  stays;
   logic                  shift_done;
   logic [COUNT_W-1:0]    count_dec;
   slot_type              new_slot;

   // Effective fill limit, capped at the slot count
   assign limit_eff  = (32'(fill_limit) > 32'(TABLE_SLOTS)) ? 32'(TABLE_SLOTS)
                                                             : 32'(fill_limit);
   assign table_full = 32'(count_ff) >= limit_eff;

   assign key_hit = (rd_data.x == req_ff.tile_x) && (rd_data.z == req_ff.tile_z);

   // Entry at j stays when its home lies cyclically in (hole, j]
   always_comb begin
      if (hole_ff <= idx_ff) begin
         stays = (hole_ff < k_ff) && (k_ff <= idx_ff);
      end else begin
         stays = (hole_ff < k_ff) || (k_ff <= idx_ff);
      end
   end

   assign count_dec = (count_ff != '0) ? COUNT_W'(count_ff - 1'b1) : count_ff;

   always_comb begin
      new_slot.valid  = 1'b1;
      new_slot.x      = req_ff.tile_x;
      new_slot.z      = req_ff.tile_z;
      new_slot.handle = req_ff.tile_handle;
   end

   // Next state and memory accesses
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      hole_in      = hole_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_req      = '0;
      shift_done   = 1'b0;

      case (state_ff)
         // Sweep the memory, one slot a cycle
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff;
            mem_req.wdata = '0;
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == SLOT_MAX) begin
               state_in   = S_IDLE;
               count_in   = '0;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(STAT_OK, '0, '0);
               end
            end
         end

         // Take an item
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.opcode == OP_CLEAR) begin
                  state_in   = S_CLEAR;
                  idx_in     = '0;
                  clr_rsp_in = 1'b1;
               end else begin
                  state_in = S_HASH;
               end
            end
         end

         // Compute the home slot, refuse inserts into a full table
         S_HASH: begin
            idx_in = slot_hash(req_ff.tile_x, req_ff.tile_z);
            cnt_in = '0;
            if ((req_ff.opcode == OP_INSERT) && table_full) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STAT_FULL, '0, count_ff);
            end else begin
               state_in = S_PROBE_RD;
            end
         end

         S_PROBE_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_ff;
            state_in      = S_PROBE_CHK;
         end

         // Check one slot, read the next one when the chain goes on
         S_PROBE_CHK: begin
            if (req_ff.opcode == OP_INSERT) begin
               if (!rd_data.valid) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = idx_ff;
                  mem_req.wdata = new_slot;
                  count_in      = COUNT_W'(count_ff + 1'b1);
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_in        = make_rsp(STAT_OK, '0, COUNT_W'(count_ff + 1'b1));
               end else begin
                  idx_in        = idx_ff + 1'b1;
                  mem_req.re    = 1'b1;
                  mem_req.raddr = idx_ff + 1'b1;
               end
            end else if (!rd_data.valid) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STAT_ABSENT, '0, count_ff);
            end else if (key_hit) begin
               if (req_ff.opcode == OP_FIND) begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(STAT_OK, rd_data.handle, count_ff);
               end else begin
                  found_in = rd_data.handle;
                  hole_in  = idx_ff;
                  idx_in   = idx_ff + 1'b1;
                  cnt_in   = '0;
                  state_in = S_SHIFT_RD;
               end
            end else if (cnt_ff == SLOT_MAX) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STAT_ABSENT, '0, count_ff);
            end else begin
               idx_in        = idx_ff + 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_ff + 1'b1;
            end
         end

         // Backward shift: read the next slot of the chain, or stop after a full turn of the table
         S_SHIFT_RD: begin
            if (cnt_ff == SLOT_MAX) begin
               shift_done = 1'b1;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_ff;
               state_in      = S_SHIFT_DAT;
            end
         end

         // Stop at an empty slot, else hash the entry found there
         S_SHIFT_DAT: begin
            if (!rd_data.valid) begin
               shift_done = 1'b1;
            end else begin
               k_in     = slot_hash(rd_data.x, rd_data.z);
               state_in = S_SHIFT_DEC;
            end
         end

         // Move the entry into the hole unless its home keeps it in place
         S_SHIFT_DEC: begin
            if (!stays) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = hole_ff;
               mem_req.wdata = rd_data;
               hole_in       = idx_ff;
            end
            idx_in   = idx_ff + 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_SHIFT_RD;
         end

         default: begin
            state_in = S_CLEAR;
            idx_in   = '0;
         end
      endcase

      // Empty the final hole and answer the remove
      if (shift_done) begin
         mem_req.we    = 1'b1;
         mem_req.waddr = hole_ff;
         mem_req.wdata = '0;
         count_in      = count_dec;
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_in        = make_rsp(STAT_OK, found_ff, count_dec);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      cnt_ff   <= cnt_in;
      hole_ff  <= hole_in;
      k_ff     <= k_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A read never meets a write to the same slot in one cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr)))
      else $error("slot read and write collide");

   // One result per item: the result strobe is never repeated back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe repeated");

   // A full status answers only an insert
   a_full_only_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STAT_FULL)) |-> (req_ff.opcode == OP_INSERT))
      else $error("full status on a non-insert item");

   // A successful insert adds exactly one entry
   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STAT_OK) && (req_ff.opcode == OP_INSERT))
      |-> (count_ff == COUNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not raise the entry count by one");

endmodule
